[rtl/dfa_token_scanner_unit_defines.svh]
// Assertion macros shared by the token scanner RTL.
// Depends on nothing; included by the modules that assert.
`ifndef DFA_TOKEN_SCANNER_UNIT_DEFINES_SVH
`define DFA_TOKEN_SCANNER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DTS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DTS_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DTS_ASSERT(label, clk, rst_n, prop, msg)
`define DTS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[rtl/dts_pkg.sv]
// Types, tables and constants of the token scanner.
// Depends on nothing.
`default_nettype none
package dts_pkg;
	localparam int unsigned NUM_KW = 7;
	localparam logic [4:0] ST_START = 5'd0;
	localparam logic [4:0] ST_ID = 5'd2;
	localparam logic [4:0] ST_STR = 5'd3;
	localparam logic [4:0] ST_DOT = 5'd19;
	localparam logic [4:0] ST_CHAR = 5'd20;
	localparam logic [4:0] ST_NUM = 5'd21;
	localparam logic [4:0] ST_DEAD = 5'd31;
	localparam logic [4:0] RESERVED_CLASS = 5'd21;

	localparam logic [0:0] KIND_CHAR = 1'b0;
	localparam logic [0:0] KIND_END = 1'b1;

	typedef logic [3:0] col_t;
	localparam col_t COL_DIGIT = 4'd0;
	localparam col_t COL_LETTER = 4'd1;
	localparam col_t COL_QUOTE = 4'd2;
	localparam col_t COL_PLUSMIN = 4'd3;
	localparam col_t COL_MULDIV = 4'd4;
	localparam col_t COL_EQ = 4'd5;
	localparam col_t COL_LT = 4'd6;
	localparam col_t COL_GT = 4'd7;
	localparam col_t COL_AMP = 4'd8;
	localparam col_t COL_BAR = 4'd9;
	localparam col_t COL_BANG = 4'd10;
	localparam col_t COL_DELIM = 4'd11;
	localparam col_t COL_DOT = 4'd12;
	localparam col_t COL_NL = 4'd13;
	localparam col_t COL_BLANK = 4'd14;
	localparam col_t COL_OTHER = 4'd15;

	typedef struct packed {
		logic [0:0] kind;
		logic [7:0] char_byte;
	} in_item_t;

	typedef struct packed {
		logic [4:0]  token_class;
		logic        token_valid;
		logic [15:0] line_number;
		logic [31:0] start_offset;
		logic [7:0]  token_length;
		logic        length_overflow;
	} out_item_t;

	// classified item passed from front to back
	typedef struct packed {
		logic       is_end;
		logic [7:0] ch;
		col_t       col_base;
		logic       is_blank;
		logic       is_nl;
		logic       is_quote;
	} cls_item_t;

	// column of a byte, with quote treated as plain quote
	function automatic col_t column_of(input logic [7:0] c);
		col_t r;
		begin
			r = COL_OTHER;
			if (c >= 8'h30 && c <= 8'h39) r = COL_DIGIT;
			else if ((c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a)) r = COL_LETTER;
			else if (c == 8'h22) r = COL_QUOTE;
			else if (c == 8'h2b || c == 8'h2d) r = COL_PLUSMIN;
			else if (c == 8'h2a || c == 8'h2f) r = COL_MULDIV;
			else if (c == 8'h3d) r = COL_EQ;
			else if (c == 8'h3c) r = COL_LT;
			else if (c == 8'h3e) r = COL_GT;
			else if (c == 8'h26) r = COL_AMP;
			else if (c == 8'h7c) r = COL_BAR;
			else if (c == 8'h21) r = COL_BANG;
			else if (c == 8'h7b || c == 8'h7d || c == 8'h28 || c == 8'h29
				|| c == 8'h2c || c == 8'h3b) r = COL_DELIM;
			else if (c == 8'h2e) r = COL_DOT;
			else if (c == 8'h0a) r = COL_NL;
			else if (c == 8'h09 || c == 8'h20) r = COL_BLANK;
			return r;
		end
	endfunction

	// transition table, dead entries as ST_DEAD
	function automatic logic [4:0] next_state(input logic [4:0] st, input col_t col);
		logic [4:0] r;
		begin
			r = ST_DEAD;
			case (st)
				5'd0: begin
					case (col)
						COL_DOT: r = ST_DOT;
						COL_NL, COL_BLANK: r = ST_START;
						COL_OTHER: r = ST_CHAR;
						default: r = 5'({1'b0, col} + 5'd1);
					endcase
				end
				5'd1: begin
					case (col)
						COL_DIGIT: r = 5'd1;
						COL_LETTER: r = ST_NUM;
						COL_DOT: r = 5'd13;
						COL_OTHER: r = ST_CHAR;
						default: r = ST_DEAD;
					endcase
				end
				5'd2: r = (col == COL_DIGIT || col == COL_LETTER) ? 5'd2 : ST_DEAD;
				5'd3: begin
					case (col)
						COL_QUOTE: r = 5'd14;
						COL_NL: r = ST_DEAD;
						default: r = 5'd3;
					endcase
				end
				5'd6, 5'd7, 5'd8, 5'd11: begin
					if (col == COL_EQ) r = 5'd15;
					else if (col == COL_OTHER) r = ST_CHAR;
				end
				5'd9: begin
					if (col == COL_AMP) r = 5'd16;
					else if (col == COL_OTHER) r = ST_CHAR;
				end
				5'd10: begin
					if (col == COL_BAR) r = 5'd17;
					else if (col == COL_OTHER) r = ST_CHAR;
				end
				5'd13, 5'd18: begin
					if (col == COL_DIGIT) r = 5'd18;
					else if (col == COL_LETTER) r = ST_NUM;
					else if (col == COL_OTHER) r = ST_CHAR;
				end
				5'd21: begin
					if (col == COL_DIGIT || col == COL_LETTER) r = ST_NUM;
					else if (col == COL_OTHER) r = ST_CHAR;
				end
				5'd4, 5'd5, 5'd12, 5'd14, 5'd15, 5'd16, 5'd17, 5'd19, 5'd20: begin
					if (col == COL_OTHER) r = ST_CHAR;
				end
				default: r = ST_DEAD;
			endcase
			return r;
		end
	endfunction

	function automatic logic accepting(input logic [4:0] st);
		logic [21:0] acc;
		begin
			acc = 22'b0001111101100111110110;
			return (st < 5'd22) ? acc[st] : 1'b0;
		end
	endfunction

	// keyword character at position p (0 beyond the word)
	function automatic logic [7:0] kw_char(input int unsigned k, input logic [2:0] p);
		logic [47:0] w;
		begin
			case (k)
				0: w = {"else", 16'h0};
				1: w = {"float", 8'h0};
				2: w = {"if", 32'h0};
				3: w = {"int", 24'h0};
				4: w = "return";
				5: w = {"void", 16'h0};
				default: w = {"while", 8'h0};
			endcase
			return (p < 3'd6) ? w[8'(47 - 8 * int'(p)) -: 8] : 8'h0;
		end
	endfunction

	function automatic logic [2:0] kw_len(input int unsigned k);
		case (k)
			0: return 3'd4;
			1: return 3'd5;
			2: return 3'd2;
			3: return 3'd3;
			4: return 3'd6;
			5: return 3'd4;
			default: return 3'd5;
		endcase
	endfunction
endpackage
`default_nettype wire

[rtl/dts_front.sv]
// Front end: accepts input items, classifies the byte, feeds the queue.
// Depends on dts_pkg.
`default_nettype none
module dts_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire dts_pkg::in_item_t   in_data,
	output logic                     q_valid,
	input  wire logic                q_ready,
	output dts_pkg::cls_item_t       q_data
);
	dts_pkg::cls_item_t cls;

	// classification
	always_comb begin
		cls.is_end = (in_data.kind == dts_pkg::KIND_END);
		cls.ch = in_data.char_byte;
		cls.col_base = dts_pkg::column_of(in_data.char_byte);
		cls.is_blank = (cls.col_base == dts_pkg::COL_BLANK);
		cls.is_nl = (cls.col_base == dts_pkg::COL_NL);
		cls.is_quote = (cls.col_base == dts_pkg::COL_QUOTE);
	end

	// two-entry queue
	dts_pkg::cls_item_t buf_q [2];
	logic               wr_ptr_q, rd_ptr_q;
	logic [1:0]         cnt_q;
	logic               push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_data = buf_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_ptr_q] <= cls;
	end
endmodule
`default_nettype wire

[rtl/dts_back.sv]
// Back end: steps the automaton, tracks the token and emits results.
// Depends on dts_pkg and the assertion macro header.
`default_nettype none
`include "dfa_token_scanner_unit_defines.svh"
module dts_back #(
	parameter int unsigned MAX_TOKEN_LEN = 256,
	parameter int unsigned LINE_BITS = 16,
	parameter int unsigned POSITION_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	output logic                    q_ready,
	input  wire dts_pkg::cls_item_t q_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output dts_pkg::out_item_t      out_data
);
	localparam int unsigned CW = $clog2(MAX_TOKEN_LEN);
	localparam logic [CW-1:0] LEN_LIMIT = CW'(MAX_TOKEN_LEN - 1);

	logic [4:0]               state_q;
	logic [LINE_BITS-1:0]     line_q;
	logic [POSITION_BITS-1:0] pos_q, start_q;
	logic [CW-1:0]            cnt_q;
	logic                     ovf_q;
	logic [7:0]               last_q;
	logic [6:0]               kw_q;

	logic take;
	assign q_ready = !out_valid || out_ready;
	assign take = q_valid && q_ready;

	logic [4:0]         nxt0, nxt;
	logic               dead, emit_now, skip, do_app, reserved, fresh;
	dts_pkg::col_t      col_cur;
	dts_pkg::out_item_t res;
	logic [6:0]         kw_base, kw_new;
	logic [CW-1:0]      cnt_base;

	// automaton step with rescan
	always_comb begin
		col_cur = q_data.col_base;
		if (q_data.is_quote && state_q == dts_pkg::ST_STR && last_q == 8'h5c)
			col_cur = dts_pkg::COL_OTHER;
		nxt0 = dts_pkg::next_state(state_q, col_cur);
		dead = (nxt0 == dts_pkg::ST_DEAD);
		nxt = dead ? dts_pkg::next_state(dts_pkg::ST_START, q_data.col_base) : nxt0;
		emit_now = q_data.is_end ? (state_q != dts_pkg::ST_START) : dead;
		skip = (nxt == dts_pkg::ST_START) && q_data.is_blank;
		do_app = !q_data.is_end && !skip && !q_data.is_nl;
		fresh = dead || (cnt_q == '0 && !ovf_q);

		reserved = 1'b0;
		for (int k = 0; k < int'(dts_pkg::NUM_KW); k++) begin
			if (kw_q[k] && cnt_q == CW'(dts_pkg::kw_len(k)) && !ovf_q) reserved = 1'b1;
		end
		if (state_q != dts_pkg::ST_ID) reserved = 1'b0;

		res.token_class = reserved ? dts_pkg::RESERVED_CLASS : 5'(state_q - 5'd1);
		res.token_valid = dts_pkg::accepting(state_q);
		res.line_number = (LINE_BITS > 16 && line_q > LINE_BITS'(16'hffff)) ? 16'hffff
			: 16'(line_q);
		res.start_offset = 32'(start_q);
		res.token_length = (CW > 8 && cnt_q > CW'(8'hff)) ? 8'hff : 8'(cnt_q);
		res.length_overflow = ovf_q || (CW > 8 && cnt_q > CW'(8'hff));

		kw_base = dead ? 7'h7f : kw_q;
		cnt_base = dead ? '0 : cnt_q;
		for (int k = 0; k < int'(dts_pkg::NUM_KW); k++) begin
			kw_new[k] = kw_base[k] && (cnt_base < CW'(dts_pkg::kw_len(k)))
				&& (dts_pkg::kw_char(k, 3'(cnt_base)) == q_data.ch);
		end
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dts_pkg::ST_START;
			line_q <= LINE_BITS'(1);
			pos_q <= '0;
			start_q <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			last_q <= 8'h0;
			kw_q <= 7'h7f;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (take) begin
				if (emit_now) out_valid <= 1'b1;
				if (q_data.is_end) begin
					state_q <= dts_pkg::ST_START;
					line_q <= LINE_BITS'(1);
					pos_q <= '0;
					start_q <= '0;
					cnt_q <= '0;
					ovf_q <= 1'b0;
					last_q <= 8'h0;
					kw_q <= 7'h7f;
				end else begin
					state_q <= nxt;
					pos_q <= pos_q + POSITION_BITS'(1);
					if (q_data.is_nl && !skip) begin
						if (line_q != '1) line_q <= line_q + LINE_BITS'(1);
					end
					if (dead) begin
						start_q <= '0;
						cnt_q <= '0;
						ovf_q <= 1'b0;
						last_q <= 8'h0;
						kw_q <= 7'h7f;
					end
					if (do_app) begin
						if (fresh) start_q <= pos_q;
						kw_q <= kw_new;
						if (cnt_base < LEN_LIMIT) cnt_q <= cnt_base + CW'(1);
						else ovf_q <= 1'b1;
						last_q <= q_data.ch;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit_now) out_data <= res;
	end

	`DTS_ASSERT(a_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "result lost under stall")
	`DTS_ASSERT(a_no_take_full, clk, arst_n, out_valid && !out_ready |-> !q_ready, "queue drained into full output")
	`DTS_ASSERT(a_end_restart, clk, arst_n, take && q_data.is_end |=> state_q == dts_pkg::ST_START && pos_q == '0, "end did not restart")
	`DTS_ASSERT(a_line_nz, clk, arst_n, 1'b1 |-> line_q != '0, "line count zero")
endmodule
`default_nettype wire

[rtl/dfa_token_scanner_unit.sv]
// Token scanner top level: links the front end, queue and back end.
// Depends on dts_pkg, dts_front and dts_back.
//
// Usage: in channel (in_valid/in_ready/in_data) takes one item per cycle while
// in_ready is high, a source byte (kind 0) or end of input (kind 1). The out
// channel (out_valid/out_ready/out_data) gives at most one token per item.
// Throughput is one item per clock unless the receiver stalls: the automaton
// step, its rescan from the start state and token bookkeeping are combinational.
// An accepted item is registered in the two-entry queue after the classifier;
// its result is then registered in the back end's output register.
// An end item reports any pending token and returns line, position and all
// token state to their reset values.
// Reset (arst_n low) empties the queue, drops any waiting result and puts the
// automaton in its start state with line 1 and position 0.
// When the receiver stalls, the result register holds, the back end stops
// and the queue fills; in_ready falls once both queue entries are taken.
`default_nettype none
module dfa_token_scanner_unit #(
	parameter int unsigned MAX_TOKEN_LEN = 256,
	parameter int unsigned LINE_BITS = 16,
	parameter int unsigned POSITION_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire dts_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output dts_pkg::out_item_t      out_data
);
	logic               q_valid, q_ready;
	dts_pkg::cls_item_t q_data;

	dts_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
	);

	dts_back #(
		.MAX_TOKEN_LEN(MAX_TOKEN_LEN), .LINE_BITS(LINE_BITS),
		.POSITION_BITS(POSITION_BITS)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);
endmodule
`default_nettype wire
